// ===== rtl/bitmap_page_allocator_top_defines.svh =====
// Assertion macros for the page allocator.
`ifndef BITMAP_PAGE_ALLOCATOR_TOP_DEFINES_SVH
`define BITMAP_PAGE_ALLOCATOR_TOP_DEFINES_SVH

// Checked only outside reset.
`define BPA_ASSERT(name, prop, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked in and out of reset.
`define BPA_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== rtl/bpa_pkg.sv =====
package bpa_pkg;

    localparam int POOL_PAGES = 4096;
    localparam int POOL_WORDS = POOL_PAGES / 32;
    localparam int WORD_AW    = $clog2(POOL_WORDS);
    localparam int MEM_AW     = 2 + WORD_AW;
    localparam int MEM_DEPTH  = 3 * POOL_WORDS;
    localparam int SIZE_W     = $clog2(POOL_PAGES + 1);
    localparam int NW_W       = $clog2(POOL_WORDS + 1);

    localparam int CFG_W   = 14;
    localparam int CNT_W   = 13;
    localparam int IDX_W   = 12;
    localparam int ADDR_W  = 32;

    localparam logic [CFG_W-1:0]  MEM_PAGES_RST  = 14'd8192;
    localparam logic [CFG_W-1:0]  RESERVED_PAGES = 14'd512;
    localparam logic [ADDR_W-1:0] KPHYS_BASE     = 32'h0010_0000 + 32'd256 * 32'd4096;
    localparam logic [ADDR_W-1:0] KVIRT_BASE     = 32'hC010_0000;

    localparam logic [1:0] POOL_KPHYS = 2'd0;
    localparam logic [1:0] POOL_UPHYS = 2'd1;
    localparam logic [1:0] POOL_KVIRT = 2'd2;
    localparam logic [1:0] POOL_NONE  = 2'd3;

    function automatic logic [CFG_W-2:0] kernel_half(input logic [CFG_W-1:0] mp);
        logic [CFG_W-1:0] f;
        f = (mp >= RESERVED_PAGES) ? mp - RESERVED_PAGES : '0;
        return f[CFG_W-1:1];
    endfunction

    function automatic logic [SIZE_W-1:0] pool_limit(input logic [CFG_W-1:0] mp,
                                                      input logic [1:0] pool);
        logic [CFG_W-1:0] f;
        logic [CFG_W-1:0] k;
        logic [CFG_W-1:0] h;
        f = (mp >= RESERVED_PAGES) ? mp - RESERVED_PAGES : '0;
        k = {1'b0, f[CFG_W-1:1]};
        h = (pool == POOL_UPHYS) ? f - k : k;
        h = {h[CFG_W-1:3], 3'b000};
        return (h > CFG_W'(POOL_PAGES)) ? SIZE_W'(POOL_PAGES) : h[SIZE_W-1:0];
    endfunction

    function automatic logic [ADDR_W-1:0] pool_base(input logic [CFG_W-1:0] mp,
                                                    input logic [1:0] pool);
        logic [ADDR_W-1:0] b;
        case (pool)
            POOL_KPHYS: b = KPHYS_BASE;
            POOL_UPHYS: b = KPHYS_BASE + ADDR_W'({kernel_half(mp), 12'h000});
            default:    b = KVIRT_BASE;
        endcase
        return b;
    endfunction

endpackage

// ===== rtl/bitmap_page_allocator_top.sv =====
// Channel | Direction | Ports                                     | Beat
// s_      | in        | s_valid s_ready s_pool s_page_count       | one request
// m_      | out       | m_valid m_ready m_granted m_start_index   | one result
//         |           | m_address                                 |
// cfg_    | in        | cfg_we cfg_wdata                          | memory_pages write
//
// Scan: reads one 32-bit bitmap word per cycle until a run ends in the current word, or
// all ceil(size/32) words on a miss; marking then rewrites each word the run covers, and
// the result is loaded into the output register. Rejected requests go straight to that load.
// Reset: the 384-word bitmap is cleared one word per cycle; s_ready stays low until then.
// Stalls: a new request is taken while a result waits in the output register;
// the next result waits for m_ready.
`include "bitmap_page_allocator_top_defines.svh"

module bitmap_page_allocator_top
    import bpa_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic [CFG_W-1:0]  cfg_wdata,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_pool,
    input  logic [CNT_W-1:0]  s_page_count,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_granted,
    output logic [IDX_W-1:0]  m_start_index,
    output logic [ADDR_W-1:0] m_address
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_MARK,
        ST_RESULT
    } state_t;

    state_t             state_reg, state_next;
    logic [CFG_W-1:0]   mem_pages_reg, mem_pages_next;
    logic [MEM_AW-1:0]  clr_reg, clr_next;
    logic [1:0]         pool_reg, pool_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [SIZE_W-1:0]  size_reg, size_next;
    logic [NW_W-1:0]    nwords_reg, nwords_next;
    logic [NW_W-1:0]    issue_reg, issue_next;
    logic [WORD_AW-1:0] proc_reg, proc_next;
    logic               dvld_reg, dvld_next;
    logic [CNT_W-1:0]   carry_reg, carry_next;
    logic [IDX_W-1:0]   start_reg, start_next;
    logic [WORD_AW-1:0] ew_reg, ew_next;
    logic [4:0]         endbit_reg, endbit_next;
    logic               granted_reg, granted_next;
    logic               m_valid_reg, m_valid_next;
    logic               m_granted_reg, m_granted_next;
    logic [IDX_W-1:0]   m_start_reg, m_start_next;
    logic [ADDR_W-1:0]  m_addr_reg, m_addr_next;

    logic [31:0]        mem [MEM_DEPTH];
    logic [31:0]        rdata_reg;
    logic [MEM_AW-1:0]  mem_raddr;
    logic [MEM_AW-1:0]  mem_waddr;
    logic [31:0]        mem_wdata;
    logic               mem_we;

    logic               has [32];
    logic [4:0]         pos [32];
    logic [CNT_W-1:0]   run [32];
    logic [31:0]        hit_vec;
    logic               any_hit;
    logic [4:0]         hit_pos;
    logic [CNT_W-1:0]   hit_start;
    logic [4:0]         mask_lo;
    logic [4:0]         mask_hi;
    logic [31:0]        mark_mask;
    logic [SIZE_W-1:0]  req_size;

    assign s_ready       = (state_reg == ST_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_granted     = m_granted_reg;
    assign m_start_index = m_start_reg;
    assign m_address     = m_addr_reg;

    assign req_size = pool_limit(mem_pages_reg, s_pool);

    // run[j]: free pages ending at bit j, found by a prefix search for the last used bit
    always_comb begin
        for (int j = 0; j < 32; j++) begin
            has[j] = rdata_reg[j];
            pos[j] = 5'(j);
        end
        for (int d = 1; d < 32; d = d * 2) begin
            for (int j = 31; j >= d; j--) begin
                if (!has[j]) begin
                    has[j] = has[j-d];
                    pos[j] = pos[j-d];
                end
            end
        end
        for (int j = 0; j < 32; j++) begin
            run[j]     = has[j] ? CNT_W'(5'(j) - pos[j]) : carry_reg + CNT_W'(j) + 1'b1;
            hit_vec[j] = (SIZE_W'({proc_reg, 5'(j)}) < size_reg) && (run[j] >= count_reg);
        end
        any_hit = |hit_vec;
        hit_pos = '0;
        for (int j = 31; j >= 0; j--) begin
            if (hit_vec[j]) begin
                hit_pos = 5'(j);
            end
        end
        hit_start = CNT_W'({proc_reg, hit_pos}) + 1'b1 - count_reg;
    end

    always_comb begin
        mask_lo   = (proc_reg == start_reg[IDX_W-1:5]) ? start_reg[4:0] : 5'd0;
        mask_hi   = (proc_reg == ew_reg) ? endbit_reg : 5'd31;
        mark_mask = (32'hFFFF_FFFF << mask_lo) & (32'hFFFF_FFFF >> (5'd31 - mask_hi));
    end

    always_comb begin
        state_next     = state_reg;
        mem_pages_next = cfg_we ? cfg_wdata : mem_pages_reg;
        clr_next       = clr_reg;
        pool_next      = pool_reg;
        count_next     = count_reg;
        size_next      = size_reg;
        nwords_next    = nwords_reg;
        issue_next     = issue_reg;
        proc_next      = proc_reg;
        dvld_next      = 1'b0;
        carry_next     = carry_reg;
        start_next     = start_reg;
        ew_next        = ew_reg;
        endbit_next    = endbit_reg;
        granted_next   = granted_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_granted_next = m_granted_reg;
        m_start_next   = m_start_reg;
        m_addr_next    = m_addr_reg;
        mem_raddr      = {pool_reg, issue_reg[WORD_AW-1:0]};
        mem_waddr      = {pool_reg, proc_reg};
        mem_wdata      = rdata_reg | mark_mask;
        mem_we         = 1'b0;

        case (state_reg)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '0;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == MEM_AW'(MEM_DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    pool_next   = s_pool;
                    count_next  = s_page_count;
                    size_next   = req_size;
                    nwords_next = NW_W'((CNT_W'(req_size) + CNT_W'(31)) >> 5);
                    issue_next  = '0;
                    carry_next  = '0;
                    start_next  = '0;
                    if (s_pool == POOL_NONE || s_page_count == '0 ||
                        s_page_count > CNT_W'(req_size)) begin
                        granted_next = 1'b0;
                        state_next   = ST_RESULT;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (issue_reg < nwords_reg) begin
                    issue_next = issue_reg + 1'b1;
                    proc_next  = issue_reg[WORD_AW-1:0];
                    dvld_next  = 1'b1;
                end
                if (dvld_reg) begin
                    carry_next = run[31];
                    if (any_hit) begin
                        start_next  = hit_start[IDX_W-1:0];
                        ew_next     = proc_reg;
                        endbit_next = hit_pos;
                        issue_next  = NW_W'(hit_start[IDX_W-1:5]);
                        dvld_next   = 1'b0;
                        state_next  = ST_MARK;
                    end else if (NW_W'(proc_reg) == nwords_reg - 1'b1) begin
                        granted_next = 1'b0;
                        start_next   = '0;
                        dvld_next    = 1'b0;
                        state_next   = ST_RESULT;
                    end
                end
            end
            ST_MARK: begin
                if (issue_reg <= NW_W'(ew_reg)) begin
                    issue_next = issue_reg + 1'b1;
                    proc_next  = issue_reg[WORD_AW-1:0];
                    dvld_next  = 1'b1;
                end
                if (dvld_reg) begin
                    mem_we = 1'b1;
                    if (proc_reg == ew_reg) begin
                        granted_next = 1'b1;
                        dvld_next    = 1'b0;
                        state_next   = ST_RESULT;
                    end
                end
            end
            ST_RESULT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next   = 1'b1;
                    m_granted_next = granted_reg;
                    m_start_next   = granted_reg ? start_reg : '0;
                    m_addr_next    = granted_reg ?
                        pool_base(mem_pages_reg, pool_reg) + ADDR_W'({start_reg, 12'h000}) :
                        '0;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            mem_pages_reg <= MEM_PAGES_RST;
            clr_reg       <= '0;
            issue_reg     <= '0;
            dvld_reg      <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            mem_pages_reg <= mem_pages_next;
            clr_reg       <= clr_next;
            issue_reg     <= issue_next;
            dvld_reg      <= dvld_next;
            m_valid_reg   <= m_valid_next;
        end
        pool_reg      <= pool_next;
        count_reg     <= count_next;
        size_reg      <= size_next;
        nwords_reg    <= nwords_next;
        proc_reg      <= proc_next;
        carry_reg     <= carry_next;
        start_reg     <= start_next;
        ew_reg        <= ew_next;
        endbit_reg    <= endbit_next;
        granted_reg   <= granted_next;
        m_granted_reg <= m_granted_next;
        m_start_reg   <= m_start_next;
        m_addr_reg    <= m_addr_next;
    end

    `BPA_ASSERT_ALWAYS(a_reset_clears, !aresetn |=> state_reg == ST_CLEAR, "no clear after reset")
    `BPA_ASSERT(a_fail_zero, m_valid && !m_granted |-> m_start_index == '0 && m_address == '0, "failed beat carries data")
    `BPA_ASSERT(a_mark_bounds, state_reg == ST_MARK && dvld_reg |-> proc_reg <= ew_reg && proc_reg >= start_reg[IDX_W-1:5], "mark outside run")
    `BPA_ASSERT(a_write_states, mem_we |-> state_reg == ST_CLEAR || state_reg == ST_MARK, "bitmap write outside clear or mark")

endmodule
